@@ design/bmhpq_pkg.sv @@
// shared types and codes of the binary max-heap priority queue
package bmhpq_pkg;

    // operation codes
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // capacity after reset
    localparam logic [7:0] CAP_RESET = 8'd128;

    // input transaction
    typedef struct packed {
        logic               operation;
        logic [31:0]        payload;
        logic signed [15:0] rank;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic [31:0]        out_payload;
        logic signed [15:0] out_rank;
        logic [1:0]         status;
        logic [7:0]         occupancy;
    } t_out_item;

    // one heap entry as held in memory
    typedef struct packed {
        logic [31:0]        payload;
        logic signed [15:0] rank;
    } t_entry;

    // control sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_UP_FIN,
        S_EX_LOAD,
        S_EX_CMP,
        S_DONE
    } t_state;

endpackage

@@ design/binary_max_heap_priority_queue_top.sv @@
// binary max-heap priority queue: heap memory, sift sequencer and result register
//
// Input channel (i_in_valid / o_in_ready, payload i_in) carries one operation per
// transaction: insert (payload, rank) or extract the entry of largest rank. Each
// operation yields exactly one output transaction (o_out_valid / i_out_ready,
// payload o_out) with the extracted entry, a status and the occupancy after it.
// The user must write the capacity register (i_cfg_we / i_cfg_wdata) only while idle; the block does not enforce it.
//
// Entries live in one DEPTH-deep memory with two registered read ports and one
// write port. The sift loop visits one heap level per cycle: the parent (insert)
// or both children (extract) are read, compared against the moving entry held in
// a register, and one entry is written back. An insert into an empty queue, a full
// insert or an empty extract skips the sift loop and goes straight to the result.
// One operation is in flight at a time; the next is accepted once the result sits
// in the output register. The output register holds the result while the receiver
// stalls; an operation accepted meanwhile runs, then waits until that result is taken.
//
// Reset empties the queue (count cleared, memory contents left as they are)
// and sets the capacity to 128; no clearing pass is needed.
module binary_max_heap_priority_queue_top #(
    parameter int DEPTH = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bmhpq_pkg::t_in_item  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bmhpq_pkg::t_out_item o_out,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata
);

    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int XW   = IW + 2;
    localparam int CMPW = (CW > 8) ? CW : 8;

    // registers
    bmhpq_pkg::t_state    r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [7:0]           r_cap;
    logic [IW-1:0]        r_idx, n_idx;
    bmhpq_pkg::t_entry    r_mov, n_mov;
    bmhpq_pkg::t_out_item r_res, n_res;
    bmhpq_pkg::t_out_item r_out, n_out;
    logic                 r_out_valid, n_out_valid;
    bmhpq_pkg::t_entry    r_rd_a, r_rd_b;
    logic [47:0]          r_mem [DEPTH];

    // memory port controls
    logic [IW-1:0]        mem_ra, mem_rb, mem_wa;
    logic                 mem_we;
    bmhpq_pkg::t_entry    mem_wd;

    // count views and capacity check
    logic [CMPW-1:0]      cnt_ext, cnt_inc_ext, cnt_dec_ext, cap_ext, cap_eff;
    logic [CW-1:0]        cnt_inc, cnt_dec;
    logic                 is_full;

    assign cnt_inc     = r_count + CW'(1);
    assign cnt_dec     = r_count - CW'(1);
    assign cnt_ext     = CMPW'(r_count);
    assign cnt_inc_ext = CMPW'(cnt_inc);
    assign cnt_dec_ext = CMPW'(cnt_dec);
    assign cap_ext     = CMPW'(r_cap);
    assign cap_eff     = (cap_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_ext;
    assign is_full     = (cnt_ext >= cap_eff);

    // sift-up step: parent of the hole and whether the moving entry climbs
    logic [IW-1:0]        up_par, up_gpar, new_par;
    logic                 up_move, up_par_root;

    assign up_par      = (r_idx - IW'(1)) >> 1;
    assign up_gpar     = (up_par - IW'(1)) >> 1;
    assign new_par     = (r_count[IW-1:0] - IW'(1)) >> 1;
    assign up_move     = ($signed(r_mov.rank) > $signed(r_rd_a.rank));
    assign up_par_root = (up_par == '0);

    // sift-down step: pick the larger child, left wins a tie
    logic [XW-1:0]        dn_l, dn_r, dn_top, dn_cl, dn_cr, cnt_x;
    logic                 dn_lv, dn_rv, dn_take_l, dn_take_r, dn_stop;
    logic signed [15:0]   dn_best;
    logic [IW-1:0]        dn_top_i;

    assign cnt_x     = XW'(r_count);
    assign dn_l      = {1'b0, r_idx, 1'b1};
    assign dn_r      = dn_l + XW'(1);
    assign dn_lv     = (dn_l < cnt_x);
    assign dn_rv     = (dn_r < cnt_x);
    assign dn_take_l = dn_lv && ($signed(r_rd_a.rank) > $signed(r_mov.rank));
    assign dn_best   = dn_take_l ? r_rd_a.rank : r_mov.rank;
    assign dn_take_r = dn_rv && ($signed(r_rd_b.rank) > $signed(dn_best));
    assign dn_stop   = !dn_take_l && !dn_take_r;
    assign dn_top    = dn_take_r ? dn_r : dn_l;
    assign dn_top_i  = dn_top[IW-1:0];
    assign dn_cl     = {1'b0, dn_top_i, 1'b1};
    assign dn_cr     = dn_cl + XW'(1);

    logic out_free;
    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bmhpq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in.operation == bmhpq_pkg::OP_INSERT) begin
                        if (is_full || r_count == '0) begin
                            n_state = bmhpq_pkg::S_DONE;
                        end else begin
                            n_state = bmhpq_pkg::S_UP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_state = bmhpq_pkg::S_DONE;
                        end else begin
                            n_state = bmhpq_pkg::S_EX_LOAD;
                        end
                    end
                end
            end
            bmhpq_pkg::S_UP: begin
                if (!up_move) begin
                    n_state = bmhpq_pkg::S_DONE;
                end else if (up_par_root) begin
                    n_state = bmhpq_pkg::S_UP_FIN;
                end
            end
            bmhpq_pkg::S_UP_FIN: begin
                n_state = bmhpq_pkg::S_DONE;
            end
            bmhpq_pkg::S_EX_LOAD: begin
                if (r_count == '0) begin
                    n_state = bmhpq_pkg::S_DONE;
                end else begin
                    n_state = bmhpq_pkg::S_EX_CMP;
                end
            end
            bmhpq_pkg::S_EX_CMP: begin
                if (dn_stop) begin
                    n_state = bmhpq_pkg::S_DONE;
                end
            end
            bmhpq_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = bmhpq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bmhpq_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_count     = r_count;
        n_idx       = r_idx;
        n_mov       = r_mov;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        mem_ra      = '0;
        mem_rb      = '0;
        mem_we      = 1'b0;
        mem_wa      = r_idx;
        mem_wd      = r_mov;
        case (r_state)
            bmhpq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_res.out_payload = '0;
                    n_res.out_rank    = '0;
                    if (i_in.operation == bmhpq_pkg::OP_INSERT) begin
                        if (is_full) begin
                            n_res.status    = bmhpq_pkg::ST_FULL;
                            n_res.occupancy = cnt_ext[7:0];
                        end else begin
                            n_res.status    = bmhpq_pkg::ST_OK;
                            n_res.occupancy = cnt_inc_ext[7:0];
                            n_count         = cnt_inc;
                            n_mov.payload   = i_in.payload;
                            n_mov.rank      = i_in.rank;
                            n_idx           = r_count[IW-1:0];
                            mem_ra          = new_par;
                            // first entry goes straight to the root
                            if (r_count == '0) begin
                                mem_we         = 1'b1;
                                mem_wa         = '0;
                                mem_wd.payload = i_in.payload;
                                mem_wd.rank    = i_in.rank;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res.status    = bmhpq_pkg::ST_EMPTY;
                            n_res.occupancy = '0;
                        end else begin
                            n_res.status    = bmhpq_pkg::ST_OK;
                            n_res.occupancy = cnt_dec_ext[7:0];
                            n_count         = cnt_dec;
                            // fetch root and last entry together
                            mem_ra          = '0;
                            mem_rb          = cnt_dec[IW-1:0];
                        end
                    end
                end
            end
            bmhpq_pkg::S_UP: begin
                mem_we = 1'b1;
                mem_wa = r_idx;
                if (up_move) begin
                    // parent moves down into the hole
                    mem_wd = r_rd_a;
                    n_idx  = up_par;
                    mem_ra = up_gpar;
                end else begin
                    mem_wd = r_mov;
                end
            end
            bmhpq_pkg::S_UP_FIN: begin
                mem_we = 1'b1;
                mem_wa = r_idx;
                mem_wd = r_mov;
            end
            bmhpq_pkg::S_EX_LOAD: begin
                n_res.out_payload = r_rd_a.payload;
                n_res.out_rank    = r_rd_a.rank;
                n_mov             = r_rd_b;
                n_idx             = '0;
                mem_ra            = IW'(1);
                mem_rb            = IW'(2);
            end
            bmhpq_pkg::S_EX_CMP: begin
                mem_we = 1'b1;
                mem_wa = r_idx;
                if (dn_stop) begin
                    mem_wd = r_mov;
                end else begin
                    // larger child moves up into the hole
                    mem_wd = dn_take_r ? r_rd_b : r_rd_a;
                    n_idx  = dn_top_i;
                    mem_ra = dn_cl[IW-1:0];
                    mem_rb = dn_cr[IW-1:0];
                end
            end
            bmhpq_pkg::S_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_out_valid = r_out_valid && !i_out_ready;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bmhpq_pkg::S_IDLE;
            r_count     <= '0;
            r_cap       <= bmhpq_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_mov <= n_mov;
        r_res <= n_res;
        r_out <= n_out;
    end

    // heap memory, one write and two registered reads per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_a <= r_mem[mem_ra];
        r_rd_b <= r_mem[mem_rb];
    end

    assign o_in_ready  = (r_state == bmhpq_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
